// ----- hw/rtl/mme_pkg.sv -----
`default_nettype none

package mme_pkg;

   localparam int DIM_W  = 4;
   localparam int IDX_W  = 3;
   localparam int VAL_W  = 16;
   localparam int PROD_W = 36;
   localparam int OP_W   = 2;
   localparam int STAT_W = 2;
   localparam int CSR_W  = 2;

   localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_SINGLE = 2'd2;

   localparam logic [CSR_W-1:0] CSR_ROWS_A = 2'd0;
   localparam logic [CSR_W-1:0] CSR_INNER  = 2'd1;
   localparam logic [CSR_W-1:0] CSR_COLS_B = 2'd2;

   localparam logic [DIM_W-1:0] DIM_RESET = 4'd2;

   typedef struct packed {
      logic [OP_W-1:0]         operation;
      logic [IDX_W-1:0]        row_index;
      logic [IDX_W-1:0]        col_index;
      logic signed [VAL_W-1:0] element_value;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]         out_row;
      logic [IDX_W-1:0]         out_col;
      logic signed [PROD_W-1:0] product_value;
      logic                     last;
      logic [STAT_W-1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0] m;
      logic [DIM_W-1:0] n;
      logic [DIM_W-1:0] p;
   } dims_type;

   // one multiply step entering the datapath pipeline
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last_t;
      logic             final_elem;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } issue_type;

   // response beat that does not go through the multiplier
   typedef struct packed {
      logic              valid;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [STAT_W-1:0] status;
   } imm_type;

   typedef struct packed {
      logic we_a;
      logic we_b;
      logic zero;
   } wr_type;

endpackage

`default_nettype wire

// ----- hw/rtl/mme_csr.sv -----
`default_nettype none

module mme_csr
   import mme_pkg::*;
#(
   parameter int MAX_DIM = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [CSR_W-1:0]   csr_index,
   input  wire logic [DIM_W-1:0]   csr_wdata,
   output dims_type                dims
);

   logic [DIM_W-1:0] rows_a_ff, rows_a_in;
   logic [DIM_W-1:0] inner_ff, inner_in;
   logic [DIM_W-1:0] cols_b_ff, cols_b_in;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

   always_comb begin
      rows_a_in = rows_a_ff;
      inner_in  = inner_ff;
      cols_b_in = cols_b_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROWS_A: rows_a_in = csr_wdata;
            CSR_INNER:  inner_in  = csr_wdata;
            CSR_COLS_B: cols_b_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= DIM_RESET;
         inner_ff  <= DIM_RESET;
         cols_b_ff <= DIM_RESET;
      end else begin
         rows_a_ff <= rows_a_in;
         inner_ff  <= inner_in;
         cols_b_ff <= cols_b_in;
      end
   end

   assign dims.m = eff_dim(rows_a_ff);
   assign dims.n = eff_dim(inner_ff);
   assign dims.p = eff_dim(cols_b_ff);

endmodule

`default_nettype wire

// ----- hw/rtl/mme_ctrl.sv -----
`default_nettype none

module mme_ctrl
   import mme_pkg::*;
#(
   parameter int MAX_DIM = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   input  wire req_type                                req_data,
   input  wire dims_type                               dims,
   input  wire logic                                   pipe_busy,
   output logic                                        busy,
   output wr_type                                      wr,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]          wr_addr,
   output issue_type                                   iss,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]          rd_a_addr,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]          rd_b_addr,
   output imm_type                                     imm
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [AW-1:0] STRIDE    = AW'(MAX_DIM);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_ISSUE = 4'b0100,
      ST_DRAIN = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [DIM_W-1:0] i_ff, i_in;
   logic [DIM_W-1:0] j_ff, j_in;
   logic [DIM_W-1:0] t_ff, t_in;
   logic [AW-1:0]    a_base_ff, a_base_in;
   logic [AW-1:0]    a_addr_ff, a_addr_in;
   logic [AW-1:0]    b_addr_ff, b_addr_in;

   logic             accept;
   logic             t_last, j_last, i_last;
   logic             in_range;
   logic [AW-1:0]    load_addr;
   logic [DIM_W-1:0] row_w, col_w;

   assign accept    = start && !busy;
   assign t_last    = (t_ff == dims.n - DIM_W'(1));
   assign j_last    = (j_ff == dims.p - DIM_W'(1));
   assign i_last    = (i_ff == dims.m - DIM_W'(1));
   assign row_w     = DIM_W'(req_data.row_index);
   assign col_w     = DIM_W'(req_data.col_index);
   assign load_addr = AW'(req_data.row_index) * STRIDE + AW'(req_data.col_index);

   always_comb begin
      if (req_data.operation == OP_WRITE_A) begin
         in_range = (row_w < dims.m) && (col_w < dims.n);
      end else begin
         in_range = (row_w < dims.n) && (col_w < dims.p);
      end
   end

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      t_in      = t_ff;
      a_base_in = a_base_ff;
      a_addr_in = a_addr_ff;
      b_addr_in = b_addr_ff;
      busy      = 1'b1;
      wr        = '0;
      wr_addr   = load_addr;
      iss       = '0;
      imm       = '0;
      rd_a_addr = a_addr_ff;
      rd_b_addr = b_addr_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            wr.we_a = 1'b1;
            wr.we_b = 1'b1;
            wr.zero = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (accept) begin
               priority if (req_data.operation == OP_WRITE_A ||
                            req_data.operation == OP_WRITE_B) begin
                  wr.we_a    = in_range && (req_data.operation == OP_WRITE_A);
                  wr.we_b    = in_range && (req_data.operation == OP_WRITE_B);
                  imm.valid  = 1'b1;
                  imm.row    = req_data.row_index;
                  imm.col    = req_data.col_index;
                  imm.status = in_range ? STAT_OK : STAT_RANGE;
               end else if (req_data.operation == OP_COMPUTE) begin
                  if (dims.m < DIM_W'(2) && dims.p < DIM_W'(2)) begin
                     imm.valid  = 1'b1;
                     imm.status = STAT_SINGLE;
                  end else begin
                     state_in  = ST_ISSUE;
                     i_in      = '0;
                     j_in      = '0;
                     t_in      = '0;
                     a_base_in = '0;
                     a_addr_in = '0;
                     b_addr_in = '0;
                  end
               end else begin
               end
            end
         end
         ST_ISSUE: begin
            iss.valid      = 1'b1;
            iss.first      = (t_ff == '0);
            iss.last_t     = t_last;
            iss.final_elem = t_last && j_last && i_last;
            iss.row        = i_ff[IDX_W-1:0];
            iss.col        = j_ff[IDX_W-1:0];
            if (!t_last) begin
               t_in      = t_ff + DIM_W'(1);
               a_addr_in = a_addr_ff + AW'(1);
               b_addr_in = b_addr_ff + STRIDE;
            end else begin
               t_in = '0;
               if (!j_last) begin
                  j_in      = j_ff + DIM_W'(1);
                  a_addr_in = a_base_ff;
                  b_addr_in = AW'(j_ff) + AW'(1);
               end else begin
                  j_in      = '0;
                  i_in      = i_ff + DIM_W'(1);
                  a_base_in = a_base_ff + STRIDE;
                  a_addr_in = a_base_ff + STRIDE;
                  b_addr_in = '0;
                  if (i_last) begin
                     state_in = ST_DRAIN;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      j_ff      <= j_in;
      t_ff      <= t_in;
      a_base_ff <= a_base_in;
      a_addr_ff <= a_addr_in;
      b_addr_ff <= b_addr_in;
   end

   a_no_write_while_issue: assert property (@(posedge clock) disable iff (reset)
      iss.valid |-> !(wr.we_a || wr.we_b))
      else $error("store write during multiply issue");

   a_final_then_drain: assert property (@(posedge clock) disable iff (reset)
      (iss.valid && iss.final_elem) |=> (state_ff == ST_DRAIN))
      else $error("last product issued without drain");

endmodule

`default_nettype wire

// ----- hw/rtl/mme_dpath.sv -----
`default_nettype none

module mme_dpath
   import mme_pkg::*;
#(
   parameter int MAX_DIM    = 8,
   parameter int DATA_WIDTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire wr_type                                 wr,
   input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     wr_addr,
   input  wire logic signed [VAL_W-1:0]                wr_value,
   input  wire issue_type                              iss,
   input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     rd_a_addr,
   input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     rd_b_addr,
   input  wire imm_type                                imm,
   output logic                                        pipe_busy,
   output logic                                        rsp_valid,
   output rsp_type                                     rsp_data
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;

   logic [DATA_WIDTH-1:0] mem_a [DEPTH];
   logic [DATA_WIDTH-1:0] mem_b [DEPTH];

   logic [DATA_WIDTH-1:0]    wr_data;
   logic [DATA_WIDTH-1:0]    rd_a_ff, rd_b_ff;
   issue_type                iss1_ff, iss2_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] acc_ff, sum;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   assign wr_data = wr.zero ? '0 : DATA_WIDTH'($unsigned(wr_value));

   always_ff @(posedge clock) begin
      if (wr.we_a) begin
         mem_a[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_a[rd_a_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.we_b) begin
         mem_b[wr_addr] <= wr_data;
      end
      rd_b_ff <= mem_b[rd_b_addr];
   end

   assign prod_in = PROD_W'($signed(rd_a_ff) * $signed(rd_b_ff));
   assign sum     = (iss2_ff.first ? '0 : acc_ff) + prod_ff;

   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      priority if (imm.valid) begin
         rsp_valid_in         = 1'b1;
         rsp_in.out_row       = imm.row;
         rsp_in.out_col       = imm.col;
         rsp_in.product_value = '0;
         rsp_in.last          = 1'b1;
         rsp_in.status        = imm.status;
      end else if (iss2_ff.valid && iss2_ff.last_t) begin
         rsp_valid_in         = 1'b1;
         rsp_in.out_row       = iss2_ff.row;
         rsp_in.out_col       = iss2_ff.col;
         rsp_in.product_value = sum;
         rsp_in.last          = iss2_ff.final_elem;
         rsp_in.status        = STAT_OK;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss1_ff      <= '0;
         iss2_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         iss1_ff      <= iss;
         iss2_ff      <= iss1_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
      if (iss2_ff.valid) begin
         acc_ff <= sum;
      end
   end

   assign pipe_busy = iss1_ff.valid || iss2_ff.valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_beat_clash: assert property (@(posedge clock) disable iff (reset)
      imm.valid |-> !(iss2_ff.valid && iss2_ff.last_t))
      else $error("status beat collides with product beat");

   a_accumulate_follows: assert property (@(posedge clock) disable iff (reset)
      (iss2_ff.valid && !iss2_ff.first) |-> $past(iss2_ff.valid))
      else $error("accumulate without preceding product");

   a_final_closes_sum: assert property (@(posedge clock) disable iff (reset)
      (iss2_ff.valid && iss2_ff.final_elem) |-> iss2_ff.last_t)
      else $error("final element flagged mid dot product");

endmodule

`default_nettype wire

// ----- hw/rtl/matrix_multiply_engine.sv -----
// loads: one beat per cycle while busy is low, status beat on rsp the cycle after start
// compute: one multiply per cycle through the single multiply-accumulate pipe (store read,
//   product, accumulator and response registers); 1x1 results give a STAT_SINGLE beat
// busy stays high until the last product beat is on rsp; rsp cannot be stalled
// reset: synchronous; busy after reset while both stores are swept to zero, sizes
//   return to 2x2x2
`default_nettype none

module matrix_multiply_engine
   import mme_pkg::*;
#(
   parameter int MAX_DIM    = 8,
   parameter int DATA_WIDTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  wire logic             csr_we,
   input  wire logic [CSR_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0] csr_wdata
);

   localparam int AW = $clog2(MAX_DIM * MAX_DIM);

   dims_type      dims;
   wr_type        wr;
   issue_type     iss;
   imm_type       imm;
   logic          pipe_busy;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_a_addr;
   logic [AW-1:0] rd_b_addr;

   mme_csr #(
      .MAX_DIM (MAX_DIM)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .dims      (dims)
   );

   mme_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .dims      (dims),
      .pipe_busy (pipe_busy),
      .busy      (busy),
      .wr        (wr),
      .wr_addr   (wr_addr),
      .iss       (iss),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .imm       (imm)
   );

   mme_dpath #(
      .MAX_DIM    (MAX_DIM),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .wr_addr   (wr_addr),
      .wr_value  (req_data.element_value),
      .iss       (iss),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .imm       (imm),
      .pipe_busy (pipe_busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
